FILE: src/vds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds_pkg
// Shared types and constants for the varying declaration scanner.
// ----------------------------------------------------------------------------
package vds_pkg;

    // Largest declared index (exclusive) that may set a mask bit.
    localparam int MAX_INDEX = 32;

    localparam int MASK_W  = 32;
    localparam int INDEX_W = 6;
    localparam logic [INDEX_W-1:0] INDEX_SAT = 6'd63;

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_UP_T  = 8'h54;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_V     = 8'h76;

    // Qualifier select codes.
    localparam logic QSEL_OUT = 1'b0;
    localparam logic QSEL_IN  = 1'b1;

    // Position inside the declaration pattern.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WS1    = 4'd1,
        PH_E      = 4'd2,
        PH_C      = 4'd3,
        PH_FOUR   = 4'd4,
        PH_WS2    = 4'd5,
        PH_T      = 4'd6,
        PH_FIRST  = 4'd7,
        PH_DIGITS = 4'd8
    } t_phase;

    // Complete scan state carried from byte to byte.
    typedef struct packed {
        logic [1:0]         qual_prog;
        logic               prev_bound;
        t_phase             phase;
        logic [INDEX_W-1:0] index_val;
        logic [MASK_W-1:0]  mask;
        logic               ended;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        qual_prog:  2'd0,
        prev_bound: 1'b1,
        phase:      PH_IDLE,
        index_val:  '0,
        mask:       '0,
        ended:      1'b0
    };

endpackage

FILE: src/varying_declaration_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varying_declaration_scanner_unit
// Scans shader text a byte at a time and reports a mask of declared
// interpolator indices when the last byte of a text arrives.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output register can take a mask;
//   per-byte compare and shift-add logic feeds the scan state registers.
// Output: the mask request appears on o_out_valid in the cycle after the
//   byte marked last is accepted, held in one output register.
// Reset: synchronous, active low; scan state returns to start of text, the
//   qualifier select clears to "out" and the output register empties.
// ----------------------------------------------------------------------------
module varying_declaration_scanner_unit
    import vds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: qualifier select (0 = "out", 1 = "in").
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    // Byte request channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_text_byte,
    input  logic              i_last_byte,
    // Mask request channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MASK_W-1:0] o_declared_mask
);

    logic              r_qsel;
    t_scan_state       r_state;
    t_scan_state       n_state;
    logic [MASK_W-1:0] n_mask;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic              in_acc;

    // The output register can take a new mask whenever it is empty or is
    // being drained in this same cycle; input bytes stall only while a
    // finished mask waits undrained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    vds_step u_step (
        .i_state (r_state),
        .i_byte  (i_text_byte),
        .i_last  (i_last_byte),
        .i_qsel  (r_qsel),
        .o_state (n_state),
        .o_mask  (n_mask)
    );

    // Configuration register; to be written only while the scanner is idle, unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsel <= QSEL_OUT;
        end else if (i_cfg_we) begin
            r_qsel <= i_cfg_data;
        end
    end

    // Scan state advances once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Output register: loaded on the last byte of a text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_out_mask <= n_mask;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_declared_mask = r_out_mask;

    // A last byte always yields a mask request on the next cycle.
    a_last_gives_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> o_out_valid)
        else $error("last byte did not produce a mask");

    // Any other byte never creates a mask request.
    a_no_spurious_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_last_byte) |=> !o_out_valid)
        else $error("mask appeared without a last byte");

    // Once the text has ended, no match is in progress.
    a_ended_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ended |-> (r_state.phase == PH_IDLE) && (r_state.qual_prog == 2'd0))
        else $error("scan active after end of text");

    // A last byte returns the scan to the start-of-text state.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_state == SCAN_RESET))
        else $error("scan state not cleared after last byte");

endmodule

FILE: src/vds_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vds_step
// Next-state logic of the scanner for one text byte.
// ----------------------------------------------------------------------------
module vds_step
    import vds_pkg::*;
(
    input  t_scan_state        i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic               i_qsel,
    output t_scan_state        o_state,
    output logic [MASK_W-1:0]  o_mask
);

    function automatic logic [MASK_W-1:0] f_commit(input logic [MASK_W-1:0] mask,
                                                   input logic [INDEX_W-1:0] idx);
        logic [MASK_W-1:0] res;
        res = mask;
        if ((int'(idx) < MAX_INDEX) && !idx[INDEX_W-1]) begin
            res = mask | (MASK_W'(1) << idx[INDEX_W-2:0]);
        end
        return res;
    endfunction

    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
    logic [9:0] acc;
    logic [1:0] q_len;
    logic [7:0] q_char;
    logic [7:0] q_first;
    logic [1:0] q_prog;
    t_scan_state s;

    assign is_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = i_byte[3:0];
    assign acc      = ({4'd0, i_state.index_val} * 10'd10) + {6'd0, digit};

    // Qualifier word letters.
    always_comb begin
        q_first = (i_qsel == QSEL_IN) ? CH_I : CH_O;
        q_len   = (i_qsel == QSEL_IN) ? 2'd2 : 2'd3;
        case (i_state.qual_prog)
            2'd1:    q_char = (i_qsel == QSEL_IN) ? CH_N : CH_U;
            2'd2:    q_char = CH_T;
            default: q_char = q_first;
        endcase
    end

    always_comb begin
        s      = i_state;
        q_prog = 2'd0;
        if (!i_state.ended) begin
            if (i_byte == CH_NUL) begin
                if (i_state.phase == PH_DIGITS) begin
                    s.mask      = f_commit(i_state.mask, i_state.index_val);
                    s.index_val = '0;
                end
                s.phase     = PH_IDLE;
                s.qual_prog = 2'd0;
                s.ended     = 1'b1;
            end else begin
                s.phase = PH_IDLE;
                case (i_state.phase)
                    PH_WS1: begin
                        if (is_blank) s.phase = PH_WS1;
                        else if (i_byte == CH_V) s.phase = PH_E;
                    end
                    PH_E:    if (i_byte == CH_E) s.phase = PH_C;
                    PH_C:    if (i_byte == CH_C) s.phase = PH_FOUR;
                    PH_FOUR: if (i_byte == CH_FOUR) s.phase = PH_WS2;
                    PH_WS2: begin
                        if (is_blank) s.phase = PH_WS2;
                        else if (i_byte == CH_O) s.phase = PH_T;
                    end
                    PH_T:    if (i_byte == CH_UP_T) s.phase = PH_FIRST;
                    PH_FIRST: begin
                        if (is_digit) begin
                            s.index_val = {2'd0, digit};
                            s.phase     = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            s.index_val = (acc > {4'd0, INDEX_SAT}) ? INDEX_SAT
                                                                    : acc[INDEX_W-1:0];
                            s.phase     = PH_DIGITS;
                        end else begin
                            s.mask      = f_commit(i_state.mask, i_state.index_val);
                            s.index_val = '0;
                        end
                    end
                    default: s.phase = PH_IDLE;
                endcase

                // Qualifier detection runs alongside the declaration match.
                if ((i_state.qual_prog != 2'd0) && (i_state.qual_prog < q_len) &&
                    (i_byte == q_char)) begin
                    q_prog = i_state.qual_prog + 2'd1;
                end else if (i_state.prev_bound && (i_byte == q_first)) begin
                    q_prog = 2'd1;
                end
                if (q_prog >= q_len) begin
                    s.qual_prog = 2'd0;
                    s.phase     = PH_WS1;
                    s.index_val = '0;
                end else begin
                    s.qual_prog = q_prog;
                end
                s.prev_bound = is_blank || (i_byte == CH_CR) || (i_byte == CH_LF);
            end
        end

        // Close a pending digit run on the final byte, then start over.
        o_mask = s.mask;
        if (!s.ended && (s.phase == PH_DIGITS)) begin
            o_mask = f_commit(s.mask, s.index_val);
        end
        o_state = i_last ? SCAN_RESET : s;
    end

endmodule

FILE: tb/sv/varying_declaration_scanner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varying_declaration_scanner_unit_tb
// Streams shader-like text through the scanner and checks every mask request
// against a cycle-free software copy of the scan, under random handshake gaps.
// ----------------------------------------------------------------------------
module varying_declaration_scanner_unit_tb;
    import vds_pkg::*;

    // Run control.
    localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;          // settle time after the last mask
    localparam int TIMEOUT_NS   = 5_000_000;  // well above the slowest legal run
    localparam int MAX_REPORTS  = 10;

    // One byte request as queued for the driver.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_req;

    // DUT connections; every input is known from time zero.
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cfg_we     = 1'b0;
    logic              cfg_data   = 1'b0;
    logic              in_valid   = 1'b0;
    logic              o_in_ready;
    logic [7:0]        text_byte  = '0;
    logic              last_byte  = 1'b0;
    logic              o_out_valid;
    logic              out_ready  = 1'b0;
    logic [MASK_W-1:0] o_declared_mask;

    varying_declaration_scanner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_text_byte     (text_byte),
        .i_last_byte     (last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_declared_mask (o_declared_mask)
    );

    // Byte requests waiting for the driver, and masks waiting for the DUT.
    t_text_req         pending_bytes[$];
    logic [MASK_W-1:0] expected_masks[$];
    logic [7:0]        text_buf[$];
    int                items_queued = 0;
    int                fault_count  = 0;

    // Idling control for driver and monitor. calm and hold_token are written by
    // the stimulus process only, with nonblocking assignments on a falling edge.
    logic calm       = 1'b0;
    int   hold_token = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   stall_left = 0;
    int   gap_left   = 0;

    // ------------------------------------------------------------------------
    // Scan predictor. It mirrors the qualifier matcher, the declaration
    // pattern walker and the mask collector, one accepted byte at a time.
    // ------------------------------------------------------------------------
    logic               sel_in;
    logic [1:0]         qual_count;
    logic               after_blank;
    t_phase             decl_phase;
    logic [INDEX_W-1:0] decl_index;
    logic [MASK_W-1:0]  found;
    logic               text_done;

    function logic is_blank_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function logic is_digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Letter at position pos of the qualifier word picked by sel.
    function logic [7:0] qual_char(logic sel, logic [1:0] pos);
        if (sel == QSEL_IN) begin
            return (pos == 2'd0) ? CH_I : CH_N;
        end
        case (pos)
            2'd0: return CH_O;
            2'd1: return CH_U;
            default: return CH_T;
        endcase
    endfunction

    function void clear_scan();
        qual_count  = 2'd0;
        after_blank = 1'b1;
        decl_phase  = PH_IDLE;
        decl_index  = '0;
        found       = '0;
        text_done   = 1'b0;
    endfunction

    function void commit_index();
        if (decl_index < MAX_INDEX && decl_index < MASK_W) begin
            found[decl_index] = 1'b1;
        end
        decl_index = '0;
    endfunction

    function void advance_phase(logic [7:0] c);
        t_phase nxt;
        int     v;
        nxt = PH_IDLE;
        case (decl_phase)
            PH_WS1: begin
                if (is_blank_char(c)) nxt = PH_WS1;
                else if (c == CH_V) nxt = PH_E;
            end
            PH_E: if (c == CH_E) nxt = PH_C;
            PH_C: if (c == CH_C) nxt = PH_FOUR;
            PH_FOUR: if (c == CH_FOUR) nxt = PH_WS2;
            PH_WS2: begin
                if (is_blank_char(c)) nxt = PH_WS2;
                else if (c == CH_O) nxt = PH_T;
            end
            PH_T: if (c == CH_UP_T) nxt = PH_FIRST;
            PH_FIRST: begin
                if (is_digit_char(c)) begin
                    decl_index = INDEX_W'(c - CH_ZERO);
                    nxt = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (is_digit_char(c)) begin
                    v = int'(decl_index) * 10 + int'(c - CH_ZERO);
                    decl_index = (v > int'(INDEX_SAT)) ? INDEX_SAT : v[INDEX_W-1:0];
                    nxt = PH_DIGITS;
                end else begin
                    commit_index();
                end
            end
            default: ;
        endcase
        decl_phase = nxt;
    endfunction

    // The qualifier word may start over at any boundary, even in the middle
    // of a declaration that is still being walked.
    function void match_qualifier(logic [7:0] c);
        int wlen;
        wlen = (sel_in == QSEL_IN) ? 2 : 3;
        if (qual_count > 0 && qual_count < wlen && c == qual_char(sel_in, qual_count)) begin
            qual_count = qual_count + 2'd1;
        end else if (after_blank && c == qual_char(sel_in, 2'd0)) begin
            qual_count = 2'd1;
        end else begin
            qual_count = 2'd0;
        end
        if (qual_count >= wlen) begin
            qual_count = 2'd0;
            decl_phase = PH_WS1;
            decl_index = '0;
        end
    endfunction

    // Returns 1 when the byte produces a mask request, with the mask in m.
    function bit scan_text_byte(logic [7:0] c, logic last, output logic [MASK_W-1:0] m);
        m = '0;
        if (!text_done) begin
            if (c == CH_NUL) begin
                if (decl_phase == PH_DIGITS) commit_index();
                decl_phase = PH_IDLE;
                qual_count = 2'd0;
                text_done  = 1'b1;
            end else begin
                advance_phase(c);
                match_qualifier(c);
                after_blank = is_blank_char(c) || c == CH_CR || c == CH_LF;
            end
        end
        if (!last) return 1'b0;
        if (!text_done && decl_phase == PH_DIGITS) commit_index();
        m = found;
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Idle gap lengths: mostly none, some short, a few long.
    // ------------------------------------------------------------------------
    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function void record_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver. It holds a byte request until the DUT takes it, runs the
    // predictor on every accepted byte, then waits out a random gap before
    // offering the next request from the pending queue.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        t_text_req         nxt;
        logic [MASK_W-1:0] m;
        logic              busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = in_valid;
            if (in_valid && o_in_ready) begin
                if (scan_text_byte(text_byte, last_byte, m)) expected_masks.push_back(m);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    text_byte <= nxt.ch;
                    last_byte <= nxt.last;
                    gap_left = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every accepted mask request is compared with the oldest
    // expectation. Ready drops for random stalls, and for one long hold-off
    // whenever the stimulus process bumps hold_token.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_proc
        logic [MASK_W-1:0] want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_masks.size() == 0) begin
                    record_fault($sformatf("mask %08h arrived with none expected",
                                           o_declared_mask));
                end else begin
                    want = expected_masks.pop_front();
                    if (o_declared_mask !== want) begin
                        record_fault($sformatf("mask mismatch: expected %08h, got %08h",
                                               want, o_declared_mask));
                    end
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Text building helpers. A text is assembled in text_buf and then moved
    // to the pending queue, with the last flag on its final byte.
    // ------------------------------------------------------------------------
    function logic [7:0] rand_byte(int lo, int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    function logic [7:0] rand_break();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function string qual_word(logic sel);
        if (sel == QSEL_IN) return "in";
        return "out";
    endfunction

    task add_word(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task add_blanks(int lo, int hi);
        repeat ($urandom_range(lo, hi)) begin
            text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
    endtask

    // Random texts are mostly declarations with random spacing and index,
    // some of them broken, mixed with separators, noise and stray fragments.
    task build_random_text();
        int r;
        int start;
        int pos;
        int idx;
        text_buf.delete();
        repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                start = text_buf.size();
                if (text_buf.size() > 0) begin
                    r = $urandom_range(0, 19);
                    if (r < 15) text_buf.push_back(rand_break());
                    else if (r < 18) text_buf.push_back(rand_byte(33, 126));
                end
                // Mostly the word being scanned for, sometimes the other one.
                if ($urandom_range(0, 19) < 17) add_word(qual_word(sel_in));
                else add_word(qual_word(~sel_in));
                add_blanks(0, 2);
                add_word("vec4");
                add_blanks(0, 2);
                add_word("oT");
                r = $urandom_range(0, 19);
                if (r < 12) idx = $urandom_range(0, 31);
                else if (r < 16) idx = $urandom_range(32, 63);
                else if (r < 18) idx = $urandom_range(64, 999);
                else idx = $urandom_range(1000, 99999999);
                if ($urandom_range(0, 9) == 0) text_buf.push_back(CH_ZERO);
                add_word($sformatf("%0d", idx));
                // Break about one declaration in five: cut it short or
                // corrupt one of its bytes.
                if ($urandom_range(0, 4) == 0) begin
                    pos = $urandom_range(start, text_buf.size() - 1);
                    if ($urandom_range(0, 1)) begin
                        while (text_buf.size() > pos) void'(text_buf.pop_back());
                    end else begin
                        text_buf[pos] = rand_byte(1, 255);
                    end
                end
            end else if (r < 70) begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_break());
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) text_buf.push_back(rand_byte(1, 255));
            end else begin
                case ($urandom_range(0, 2))
                    0: add_word("vec4 oT5");
                    1: add_word("oT12");
                    default: add_word(" in out ");
                endcase
            end
        end
        if (text_buf.size() == 0) text_buf.push_back(rand_byte(1, 255));
    endtask

    // Moves text_buf to the pending queue. With a random ending the text may
    // be cut by a zero byte, followed by ignored bytes or ending on the zero.
    task queue_text(bit random_end);
        int r;
        if (random_end) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                text_buf.push_back(CH_NUL);
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_byte(0, 255));
            end else if (r < 14) begin
                text_buf.push_back(CH_NUL);
            end
        end
        for (int i = 0; i < text_buf.size(); i++) begin
            pending_bytes.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1)});
        end
        items_queued += text_buf.size();
        text_buf.delete();
    endtask

    task run_random(int count);
        int goal;
        goal = items_queued + count;
        while (items_queued < goal) begin
            build_random_text();
            queue_text(1'b1);
        end
    endtask

    // Waits until the driver has nothing left and every mask has come back,
    // then lets the output register settle.
    task wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_valid || expected_masks.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The qualifier select is only written with the scanner idle.
    task set_qualifier(logic sel);
        wait_drained();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= sel;
        sel_in = sel;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus. Reset, a short directed set of texts, then four random
    // phases that alternate the qualifier and vary the idling pattern.
    // ------------------------------------------------------------------------
    initial begin : stimulus_proc
        sel_in = QSEL_OUT;
        clear_scan();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Declaration with no spaces at all; the last byte ends the digit
        // run and sets the top mask bit.
        add_word("outvec4oT31");
        queue_text(1'b0);
        // A qualifier restarting inside a failed match, an index past the
        // saturation point, a zero byte ending the digits and a byte after
        // the zero that must be ignored.
        add_word("out outvec4oT64");
        text_buf.push_back(CH_NUL);
        text_buf.push_back(8'hFF);
        queue_text(1'b0);
        // A text that is nothing but its terminating zero.
        text_buf.push_back(CH_NUL);
        queue_text(1'b0);

        // Switch to "in" declarations; the sender pauses here until every
        // mask requested so far has come back.
        set_qualifier(QSEL_IN);
        add_word("in\tvec4 oT0");
        queue_text(1'b0);
        run_random(270);

        // Back to "out" with no idling on either side.
        set_qualifier(QSEL_OUT);
        calm <= 1'b1;
        run_random(270);

        // "in" again; the receiver holds off for a long stretch while short
        // texts keep coming, so the output register fills and input stalls.
        set_qualifier(QSEL_IN);
        calm <= 1'b0;
        hold_token <= hold_token + 1;
        repeat (12) begin
            text_buf.push_back(rand_byte(1, 255));
            queue_text(1'b0);
        end
        run_random(270);

        set_qualifier(QSEL_OUT);
        run_random(270);

        wait_drained();
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop in case the DUT hangs a handshake.
    initial begin : watchdog_proc
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
